// File: hw/rtl/function_time_profiler_unit_macros.svh
// Assertion macros shared by the profiler checker.
`ifndef FUNCTION_TIME_PROFILER_UNIT_MACROS_SVH
`define FUNCTION_TIME_PROFILER_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FTP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FTP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: hw/rtl/ftp_pkg.sv
// ----------------------------------------------------------------------------
// ftp_pkg
// Shared types and codes of the function time profiler.
// ----------------------------------------------------------------------------
package ftp_pkg;
    localparam logic [1:0] OP_ENTER  = 2'd0;
    localparam logic [1:0] OP_EXIT   = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOENTRY = 2'd2;

    // Byte address of the report limit register.
    localparam logic [1:0] REG_REPORT_LIMIT = 2'd0;

    localparam int MAX_ROWS = 16;

    // One classified command handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] func_id;
        logic [63:0] stamp;
    } cmd_t;
endpackage

// File: hw/rtl/ftp_front.sv
// ----------------------------------------------------------------------------
// ftp_front
// Accepts commands and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module ftp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  ftp_pkg::cmd_t cmd_in,
    output logic          busy,
    output logic          q_valid,
    output ftp_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import ftp_pkg::*;

    cmd_t q_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;
    logic       push;

    // One item is in work at a time, so the queue never holds more than one.
    assign busy    = (cnt_reg != 2'd0);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = q_reg[rd_reg];

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= cmd_in;
        end
    end

    // Queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
    end
endmodule

// File: hw/rtl/ftp_back.sv
// ----------------------------------------------------------------------------
// ftp_back
// Executes commands against the profile table with a small sequencer.
// ----------------------------------------------------------------------------
module ftp_back #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  ftp_pkg::cmd_t q_cmd,
    output logic          q_pop,
    input  logic [4:0]    report_limit,
    output logic          done,
    output logic [1:0]    status,
    output logic          row_valid,
    output logic [31:0]   row_id,
    output logic [31:0]   row_calls,
    output logic [63:0]   row_time,
    output logic          last_row
);
    import ftp_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_UPD, S_UPD2, S_SCAN, S_EMIT, S_FLUSH
    } state_t;

    state_t state_reg;
    logic [31:0] ids_reg    [TABLE_DEPTH];
    logic [31:0] calls_reg  [TABLE_DEPTH];
    logic [63:0] total_reg  [TABLE_DEPTH];
    logic [63:0] enter_reg  [TABLE_DEPTH];
    logic [63:0] paused_reg [TABLE_DEPTH];
    logic [CW-1:0] parent_reg [TABLE_DEPTH];
    logic [CW-1:0] used_reg;
    logic [CW-1:0] cur_reg;
    logic [31:0]   rec_reg;
    cmd_t          cmd_reg;
    logic          hit_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] scan_reg;
    logic [CW-1:0] row_cnt_reg;
    logic [CW-1:0] limit_reg;
    logic [63:0]   prev_reg;
    logic [63:0]   best_reg;
    logic          pick_ok_reg;
    logic [IW-1:0] pick_reg;
    logic [IW-1:0] pend_reg;
    logic [63:0]   span_reg;
    logic          any_row_reg;

    // Parallel ID match over the used entries, lowest index wins.
    logic          hit;
    logic [IW-1:0] hit_idx;
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if ((CW'(i) < used_reg) && ids_reg[i] == cmd_reg.func_id)
            begin
                hit     = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // Candidate test for one scanned entry.
    logic [63:0] t_scan;
    logic        cand;
    assign t_scan = total_reg[scan_reg];
    assign cand   = (t_scan > best_reg) && (row_cnt_reg == '0 || t_scan < prev_reg);

    logic [CW-1:0] lim5;
    assign lim5 = (CW'(report_limit) > used_reg || report_limit > 5'd16)
                  ? ((used_reg < CW'(MAX_ROWS)) ? used_reg : CW'(MAX_ROWS))
                  : CW'(report_limit);

    assign q_pop = (state_reg == S_IDLE) && q_valid;

    // Sequencer, table and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            cur_reg     <= '0;
            rec_reg     <= '0;
            done        <= 1'b0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                calls_reg[i]  <= '0;
                total_reg[i]  <= '0;
                paused_reg[i] <= '0;
                parent_reg[i] <= '0;
            end
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg   <= q_cmd;
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    hit_reg     <= hit;
                    idx_reg     <= hit ? hit_idx : used_reg[IW-1:0];
                    scan_reg    <= '0;
                    row_cnt_reg <= '0;
                    limit_reg   <= lim5;
                    best_reg    <= '0;
                    pick_ok_reg <= 1'b0;
                    any_row_reg <= 1'b0;
                    state_reg   <= S_UPD;
                end
                S_UPD:
                begin
                    status    <= ST_OK;
                    row_valid <= 1'b0;
                    row_id    <= '0;
                    row_calls <= '0;
                    row_time  <= '0;
                    last_row  <= 1'b1;
                    state_reg <= S_IDLE;
                    case (cmd_reg.op)
                        OP_ENTER:
                        begin
                            if (!hit_reg && used_reg >= CW'(TABLE_DEPTH))
                            begin
                                status <= ST_FULL;
                                done   <= 1'b1;
                            end
                            else
                            begin
                                if (!hit_reg)
                                begin
                                    ids_reg[idx_reg] <= cmd_reg.func_id;
                                    used_reg <= used_reg + 1'b1;
                                end
                                if (cur_reg != '0 && cur_reg == CW'(idx_reg) + 1'b1)
                                begin
                                    rec_reg <= rec_reg + 32'd1;
                                end
                                else
                                begin
                                    parent_reg[idx_reg] <= cur_reg;
                                    cur_reg <= CW'(idx_reg) + 1'b1;
                                    calls_reg[idx_reg] <= calls_reg[idx_reg] + 32'd1;
                                    enter_reg[idx_reg] <= cmd_reg.stamp;
                                    paused_reg[idx_reg] <= '0;
                                end
                                done <= 1'b1;
                            end
                        end
                        OP_EXIT:
                        begin
                            if (!hit_reg)
                            begin
                                status <= ST_NOENTRY;
                                done   <= 1'b1;
                            end
                            else if (rec_reg != '0)
                            begin
                                rec_reg <= rec_reg - 32'd1;
                                done    <= 1'b1;
                            end
                            else
                            begin
                                span_reg  <= cmd_reg.stamp - enter_reg[idx_reg];
                                state_reg <= S_UPD2;
                            end
                        end
                        OP_REPORT:
                        begin
                            if (limit_reg == '0)
                            begin
                                done <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        default:
                        begin
                            for (int i = 0; i < TABLE_DEPTH; i++)
                            begin
                                calls_reg[i]  <= '0;
                                total_reg[i]  <= '0;
                                paused_reg[i] <= '0;
                                parent_reg[i] <= '0;
                            end
                            used_reg <= '0;
                            cur_reg  <= '0;
                            done     <= 1'b1;
                        end
                    endcase
                end
                S_UPD2:
                begin
                    // Exclusive time, then charge the span to the parent.
                    total_reg[idx_reg] <= total_reg[idx_reg] + span_reg
                                          - paused_reg[idx_reg];
                    cur_reg <= parent_reg[idx_reg];
                    if (parent_reg[idx_reg] != '0)
                    begin
                        paused_reg[IW'(parent_reg[idx_reg] - 1'b1)] <=
                            paused_reg[IW'(parent_reg[idx_reg] - 1'b1)] + span_reg;
                    end
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_SCAN:
                begin
                    // One entry per cycle; the pick is the running maximum below the previous row's time.
                    if (CW'(scan_reg) < used_reg && cand)
                    begin
                        best_reg    <= t_scan;
                        pick_reg    <= scan_reg;
                        pick_ok_reg <= 1'b1;
                    end
                    if (CW'(scan_reg) + 1'b1 >= used_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                S_EMIT:
                begin
                    // A found row is held back for one scan, so that the scan
                    // after it tells whether it closes the report.
                    if (any_row_reg)
                    begin
                        status    <= ST_OK;
                        row_valid <= 1'b1;
                        row_id    <= ids_reg[pend_reg];
                        row_calls <= calls_reg[pend_reg];
                        row_time  <= prev_reg;
                        last_row  <= !pick_ok_reg;
                        done      <= 1'b1;
                    end
                    else if (!pick_ok_reg)
                    begin
                        status    <= ST_OK;
                        row_valid <= 1'b0;
                        row_id    <= '0;
                        row_calls <= '0;
                        row_time  <= '0;
                        last_row  <= 1'b1;
                        done      <= 1'b1;
                    end
                    if (pick_ok_reg)
                    begin
                        pend_reg    <= pick_reg;
                        prev_reg    <= best_reg;
                        any_row_reg <= 1'b1;
                        row_cnt_reg <= row_cnt_reg + 1'b1;
                        best_reg    <= '0;
                        pick_ok_reg <= 1'b0;
                        scan_reg    <= '0;
                        state_reg   <= (row_cnt_reg + 1'b1 >= limit_reg) ? S_FLUSH : S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FLUSH:
                begin
                    // The held row reached the limit and closes the report.
                    status    <= ST_OK;
                    row_valid <= 1'b1;
                    row_id    <= ids_reg[pend_reg];
                    row_calls <= calls_reg[pend_reg];
                    row_time  <= prev_reg;
                    last_row  <= 1'b1;
                    done      <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// File: hw/rtl/function_time_profiler_unit.sv
// ----------------------------------------------------------------------------
// function_time_profiler_unit
// Profiler top level: APB register, command front end and table back end.
// ----------------------------------------------------------------------------
// With the back end idle, enter and clear give done from S_UPD, after S_IDLE and S_LOOK; a timed exit adds S_UPD2.
// Busy is high while a command waits in the queue; one more may queue during execution.
// A report scans the used entries once per row, plus once more to find its end
// unless the limit closes it; rows come one per done beat, no stall.
// Reset empties the table, zeroes the pointers and sets report_limit to 16.
module function_time_profiler_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [31:0] func_id,
    input  logic [63:0] stamp,
    output logic        done,
    output logic [1:0]  status,
    output logic        row_valid,
    output logic [31:0] row_id,
    output logic [31:0] row_calls,
    output logic [63:0] row_time,
    output logic        last_row
);
    import ftp_pkg::*;

    logic [4:0] limit_reg;
    cmd_t       cmd_in;
    cmd_t       q_cmd;
    logic       q_valid;
    logic       q_pop;
    logic       fe_busy;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_REPORT_LIMIT) ? {27'd0, limit_reg} : 32'd0;

    // Report limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 5'd16;
        end
        else if (psel && penable && pwrite && paddr == REG_REPORT_LIMIT)
        begin
            limit_reg <= pwdata[4:0];
        end
    end

    assign cmd_in = '{op: op, func_id: func_id, stamp: stamp};
    assign busy   = fe_busy || q_valid;

    ftp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd_in  (cmd_in),
        .busy    (fe_busy),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    ftp_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .report_limit (limit_reg),
        .done         (done),
        .status       (status),
        .row_valid    (row_valid),
        .row_id       (row_id),
        .row_calls    (row_calls),
        .row_time     (row_time),
        .last_row     (last_row)
    );
endmodule

// File: hw/rtl/ftp_checker.sv
// ----------------------------------------------------------------------------
// ftp_props
// Port-level checks of the profiler, bound to the top level.
// ----------------------------------------------------------------------------
`include "function_time_profiler_unit_macros.svh"
module ftp_props (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic       row_valid,
    input logic       last_row,
    input logic       pready
);
    import ftp_pkg::*;

    // An accepted command makes the unit busy next cycle.
    `FTP_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
    // Error beats never carry a row and always close the item.
    `FTP_ASSERT_IMP(a_err_last, done && status != ST_OK, !row_valid && last_row)
    // Status codes stay in range.
    `FTP_ASSERT_IMP(a_status_rng, done, status == ST_OK || status == ST_FULL || status == ST_NOENTRY)
    // The register port never waits.
    `FTP_ASSERT_IMP(a_pready, 1'b1, pready)
endmodule

bind function_time_profiler_unit ftp_props u_ftp_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .row_valid (row_valid),
    .last_row  (last_row),
    .pready    (pready)
);
